// ===== rtl/ccc_pkg.sv =====
// ccc_pkg: types, constants and codes for the calendar clock
// used by the interfaces, the divider, the month table, the top level and the checker
package ccc_pkg;

  localparam int MONTH_SLOTS   = 32;
  localparam int MS_AW         = (MONTH_SLOTS > 2) ? $clog2(MONTH_SLOTS) : 1;
  localparam int MIN_PER_HOUR  = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int DVD_W         = 16;
  localparam int DVS_W         = 8;
  localparam int DIV_STEPS     = DVD_W;
  localparam int DIV_CW        = $clog2(DIV_STEPS);

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  typedef logic [0:0] cfg_idx_t;
  typedef logic [4:0] cfg_data_t;

  localparam cfg_idx_t CFG_DAYS_PER_WEEK   = 1'b0;
  localparam cfg_idx_t CFG_MONTHS_PER_YEAR = 1'b1;

  typedef struct packed {
    logic       func;
    logic [4:0] month_index;
    logic [7:0] month_days;
    logic [7:0] leap_period;
    logic [4:0] dawn_hour_in;
    logic [5:0] dawn_minute_in;
    logic [4:0] sunset_hour_in;
    logic [5:0] sunset_minute_in;
    logic [2:0] season_in;
  } in_item_t;

  typedef struct packed {
    logic        date_changed;
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic [8:0]  day_now;
    logic [4:0]  weekday_now;
    logic [4:0]  month_now;
    logic [15:0] year_now;
    logic [4:0]  dawn_hour_out;
    logic [5:0]  dawn_minute_out;
    logic [4:0]  sunset_hour_out;
    logic [5:0]  sunset_minute_out;
    logic [2:0]  season_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0] days;
    logic [7:0] leap;
    logic [4:0] dawn_h;
    logic [5:0] dawn_m;
    logic [4:0] sun_h;
    logic [5:0] sun_m;
    logic [2:0] season;
  } month_entry_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/ccc_if.sv =====
// ccc_in_if, ccc_out_if: valid/ready request channels of the calendar clock
// depends on ccc_pkg for the payload types
interface ccc_in_if;
  logic             valid;
  logic             ready;
  ccc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ccc_out_if;
  logic              valid;
  logic              ready;
  ccc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ccc_div.sv =====
// ccc_div: restoring divider, one quotient bit per cycle, returns the remainder
// depends on ccc_pkg
module ccc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ccc_pkg::div_req_t req,
  output ccc_pkg::div_rsp_t rsp
);
  import ccc_pkg::*;

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = req.dividend;
      dvs_nxt = req.divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/ccc_table.sv =====
// ccc_table: month table memory with per-entry valid bits and registered read
// depends on ccc_pkg; entries not written since reset read as zero
module ccc_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [4:0]            waddr,
  input  ccc_pkg::month_entry_t wdata,
  input  logic [4:0]            raddr,
  output ccc_pkg::month_entry_t rdata
);
  import ccc_pkg::*;

  month_entry_t           mem [MONTH_SLOTS];
  logic [MONTH_SLOTS-1:0] valid_r;
  month_entry_t           rdata_r;
  logic                   w_ok;
  logic                   r_ok;
  logic [MS_AW-1:0]       widx;
  logic [MS_AW-1:0]       ridx;

  assign w_ok = 7'(waddr) < 7'(MONTH_SLOTS);
  assign r_ok = 7'(raddr) < 7'(MONTH_SLOTS);
  assign widx = MS_AW'(waddr);
  assign ridx = MS_AW'(raddr);

  always_ff @(posedge clk) begin
    if (we && w_ok) begin
      mem[widx] <= wdata;
    end
    rdata_r <= (r_ok && valid_r[ridx]) ? mem[ridx] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we && w_ok) begin
      valid_r[widx] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/configurable_calendar_clock.sv =====
// configurable_calendar_clock: calendar clock with a programmable month table
// depends on ccc_pkg, ccc_if, ccc_div and ccc_table
//
//   channel  dir  signals                     request
//   in_ch    in   valid ready data            one tick or one month table load
//   out_ch   out  valid ready data            clock state and latched month data
//   cfg      in   cfg_we cfg_index cfg_data   days_per_week, months_per_year
//
// a load goes from idle straight to the output state; a tick steps through the
// weekday, leap, month, fetch, latch and output states, with a division on the shared
// remainder unit for the weekday when it passes days_per_week and for year mod leap period when that is nonzero
// synchronous reset sets clock, latches and config to their defaults and clears all table valid bits
// in_ch.ready is high only when idle; a result waiting in the output register
// does not stall the acceptance of the next request, only that request's finish
module configurable_calendar_clock (
  input  logic               clk,
  input  logic               rst_n,
  ccc_in_if.sink             in_ch,
  ccc_out_if.source          out_ch,
  input  logic               cfg_we,
  input  ccc_pkg::cfg_idx_t  cfg_index,
  input  ccc_pkg::cfg_data_t cfg_data
);
  import ccc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WDAY  = 4'd1;
  localparam logic [3:0] ST_WDIV  = 4'd2;
  localparam logic [3:0] ST_LEAP  = 4'd3;
  localparam logic [3:0] ST_LDIV  = 4'd4;
  localparam logic [3:0] ST_MON   = 4'd5;
  localparam logic [3:0] ST_FETCH = 4'd6;
  localparam logic [3:0] ST_LATCH = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]   state_r, state_nxt;
  logic [5:0]   minute_r, minute_nxt;
  logic [4:0]   hour_r, hour_nxt;
  logic [8:0]   day_r, day_nxt;
  logic [4:0]   weekday_r, weekday_nxt;
  logic [4:0]   month_r, month_nxt;
  logic [15:0]  year_r, year_nxt;
  logic         started_r, started_nxt;
  logic [4:0]   dawn_h_r, dawn_h_nxt;
  logic [5:0]   dawn_m_r, dawn_m_nxt;
  logic [4:0]   sun_h_r, sun_h_nxt;
  logic [5:0]   sun_m_r, sun_m_nxt;
  logic [2:0]   season_r, season_nxt;
  logic [4:0]   dpw_r, dpw_nxt;
  logic [4:0]   mpy_r, mpy_nxt;
  logic         changed_r, changed_nxt;
  logic         daychg_r, daychg_nxt;
  logic [5:0]   wd_inc_r, wd_inc_nxt;
  logic         leap_hit_r, leap_hit_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_data_r, out_data_nxt;

  logic         accept;
  logic         tbl_we;
  month_entry_t tbl_wdata;
  month_entry_t ent;
  div_req_t     div_req;
  div_rsp_t     div_rsp;
  logic [4:0]   dpw;
  logic [5:0]   min_inc;
  logic         min_wrap;
  logic [4:0]   hour_tmp;
  logic         hour_wrap;
  logic [8:0]   mlen;
  logic         day_over;
  logic [5:0]   month_tmp;
  logic         year_over;

  assign accept = in_ch.valid && (state_r == ST_IDLE);
  assign in_ch.ready = (state_r == ST_IDLE);

  assign tbl_we = accept && (in_ch.data.func == FUNC_LOAD);
  assign tbl_wdata.days   = in_ch.data.month_days;
  assign tbl_wdata.leap   = in_ch.data.leap_period;
  assign tbl_wdata.dawn_h = in_ch.data.dawn_hour_in;
  assign tbl_wdata.dawn_m = in_ch.data.dawn_minute_in;
  assign tbl_wdata.sun_h  = in_ch.data.sunset_hour_in;
  assign tbl_wdata.sun_m  = in_ch.data.sunset_minute_in;
  assign tbl_wdata.season = in_ch.data.season_in;

  ccc_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (tbl_we),
    .waddr (in_ch.data.month_index),
    .wdata (tbl_wdata),
    .raddr (month_r),
    .rdata (ent)
  );

  ccc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign dpw       = (dpw_r == 5'd0) ? 5'd1 : dpw_r;
  assign min_inc   = minute_r + 6'd1;
  assign min_wrap  = min_inc >= 6'(MIN_PER_HOUR);
  assign hour_tmp  = min_wrap ? hour_r + 5'd1 : hour_r;
  assign hour_wrap = hour_tmp >= 5'(HOURS_PER_DAY);
  assign mlen      = {1'b0, ent.days} + {8'd0, leap_hit_r};
  assign day_over  = day_r > mlen;
  assign month_tmp = day_over ? {1'b0, month_r} + 6'd1 : {1'b0, month_r};
  assign year_over = month_tmp > {1'b0, mpy_r};

  always_comb begin
    state_nxt     = state_r;
    minute_nxt    = minute_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    weekday_nxt   = weekday_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    started_nxt   = started_r;
    dawn_h_nxt    = dawn_h_r;
    dawn_m_nxt    = dawn_m_r;
    sun_h_nxt     = sun_h_r;
    sun_m_nxt     = sun_m_r;
    season_nxt    = season_r;
    dpw_nxt       = dpw_r;
    mpy_nxt       = mpy_r;
    changed_nxt   = changed_r;
    daychg_nxt    = daychg_r;
    wd_inc_nxt    = wd_inc_r;
    leap_hit_nxt  = leap_hit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    div_req       = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DAYS_PER_WEEK:   dpw_nxt = cfg_data;
        CFG_MONTHS_PER_YEAR: mpy_nxt = cfg_data;
        default:             mpy_nxt = mpy_r;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          changed_nxt = 1'b0;
          if (in_ch.data.func == FUNC_LOAD) begin
            state_nxt = ST_OUT;
          end else begin
            minute_nxt  = min_wrap ? 6'd0 : min_inc;
            hour_nxt    = hour_wrap ? 5'd0 : hour_tmp;
            daychg_nxt  = hour_wrap;
            changed_nxt = hour_wrap;
            wd_inc_nxt  = {1'b0, weekday_r} + 6'd1;
            if (hour_wrap) begin
              day_nxt = day_r + 9'd1;
            end
            state_nxt = ST_WDAY;
          end
        end
      end
      ST_WDAY: begin
        state_nxt = ST_LEAP;
        if (daychg_r) begin
          if (wd_inc_r <= {1'b0, dpw}) begin
            weekday_nxt = wd_inc_r[4:0];
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DVD_W'(wd_inc_r);
            div_req.divisor  = DVS_W'(dpw);
            state_nxt        = ST_WDIV;
          end
        end
      end
      ST_WDIV: begin
        if (div_rsp.done) begin
          weekday_nxt = (div_rsp.rem == '0) ? dpw : div_rsp.rem[4:0];
          state_nxt   = ST_LEAP;
        end
      end
      ST_LEAP: begin
        if (ent.leap != 8'd0) begin
          div_req.start    = 1'b1;
          div_req.dividend = year_r;
          div_req.divisor  = ent.leap;
          state_nxt        = ST_LDIV;
        end else begin
          leap_hit_nxt = 1'b0;
          state_nxt    = ST_MON;
        end
      end
      ST_LDIV: begin
        if (div_rsp.done) begin
          leap_hit_nxt = (div_rsp.rem == '0);
          state_nxt    = ST_MON;
        end
      end
      ST_MON: begin
        if (day_over) begin
          day_nxt     = 9'd1;
          changed_nxt = 1'b1;
        end
        if (year_over) begin
          month_nxt   = 5'd1;
          year_nxt    = year_r + 16'd1;
          changed_nxt = 1'b1;
        end else begin
          month_nxt = month_tmp[4:0];
        end
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        if (changed_r || !started_r) begin
          dawn_h_nxt  = ent.dawn_h;
          dawn_m_nxt  = ent.dawn_m;
          sun_h_nxt   = ent.sun_h;
          sun_m_nxt   = ent.sun_m;
          season_nxt  = ent.season;
          started_nxt = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.date_changed      = changed_r;
          out_data_nxt.minute_now        = minute_r;
          out_data_nxt.hour_now          = hour_r;
          out_data_nxt.day_now           = day_r;
          out_data_nxt.weekday_now       = weekday_r;
          out_data_nxt.month_now         = month_r;
          out_data_nxt.year_now          = year_r;
          out_data_nxt.dawn_hour_out     = dawn_h_r;
          out_data_nxt.dawn_minute_out   = dawn_m_r;
          out_data_nxt.sunset_hour_out   = sun_h_r;
          out_data_nxt.sunset_minute_out = sun_m_r;
          out_data_nxt.season_out        = season_r;
          state_nxt                      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      minute_r    <= 6'd0;
      hour_r      <= 5'd0;
      day_r       <= 9'd1;
      weekday_r   <= 5'd1;
      month_r     <= 5'd1;
      year_r      <= 16'd1;
      started_r   <= 1'b0;
      dawn_h_r    <= 5'd7;
      dawn_m_r    <= 6'd30;
      sun_h_r     <= 5'd19;
      sun_m_r     <= 6'd30;
      season_r    <= 3'd0;
      dpw_r       <= 5'd7;
      mpy_r       <= 5'd12;
      changed_r   <= 1'b0;
      daychg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      minute_r    <= minute_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      weekday_r   <= weekday_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      started_r   <= started_nxt;
      dawn_h_r    <= dawn_h_nxt;
      dawn_m_r    <= dawn_m_nxt;
      sun_h_r     <= sun_h_nxt;
      sun_m_r     <= sun_m_nxt;
      season_r    <= season_nxt;
      dpw_r       <= dpw_nxt;
      mpy_r       <= mpy_nxt;
      changed_r   <= changed_nxt;
      daychg_r    <= daychg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wd_inc_r   <= wd_inc_nxt;
    leap_hit_r <= leap_hit_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

// ===== rtl/ccc_chk.sv =====
// ccc_chk: port-level checks on the calendar clock, bound to the top level
// depends on ccc_pkg and ccc_if
module ccc_chk (
  input logic       clk,
  input logic       rst_n,
  ccc_in_if.sink    in_ch,
  ccc_out_if.source out_ch
);
  import ccc_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("ready right after an accepted request");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.minute_now < 6'(MIN_PER_HOUR))
      && (out_ch.data.hour_now < 5'(HOURS_PER_DAY))
      && (out_ch.data.day_now != 9'd0)
      && (out_ch.data.weekday_now != 5'd0)
      && (out_ch.data.month_now != 5'd0))
    else $error("clock field out of range");

endmodule

bind configurable_calendar_clock ccc_chk u_ccc_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking testbench for the calendar clock with its month table
// depends on ccc_pkg, ccc_if and configurable_calendar_clock; predicts every result
// in a local calendar model and compares it field by field with the block's output
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  cfg_data_t cfg_data;

  ccc_in_if in_if();
  ccc_out_if out_if();

  configurable_calendar_clock uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  int cal_minute = 0;
  int cal_hour = 0;
  int cal_day = 1;
  int cal_weekday = 1;
  int cal_month = 1;
  int cal_year = 1;
  bit cal_started = 1'b0;
  int week_len = 7;
  int year_len = 12;
  month_entry_t month_tab [MONTH_SLOTS];
  month_entry_t lat_entry = '{days: 8'd0, leap: 8'd0, dawn_h: 5'd7, dawn_m: 6'd30,
                              sun_h: 5'd19, sun_m: 6'd30, season: 3'd0};

  out_item_t expected_dates [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic month_entry_t read_month(input int m);
    if (m < MONTH_SLOTS) begin
      return month_tab[m];
    end
    return '0;
  endfunction

  function automatic out_item_t advance_calendar(input in_item_t it);
    out_item_t r;
    month_entry_t e;
    bit changed;
    int wk;
    int len;
    int lp;
    changed = 1'b0;
    if (it.func == FUNC_LOAD) begin
      if (it.month_index < MONTH_SLOTS) begin
        month_tab[it.month_index] = '{days: it.month_days, leap: it.leap_period,
                                      dawn_h: it.dawn_hour_in, dawn_m: it.dawn_minute_in,
                                      sun_h: it.sunset_hour_in, sun_m: it.sunset_minute_in,
                                      season: it.season_in};
      end
    end else begin
      wk = (week_len == 0) ? 1 : week_len;
      cal_minute++;
      if (cal_minute >= MIN_PER_HOUR) begin
        cal_minute = 0;
        cal_hour++;
      end
      if (cal_hour >= HOURS_PER_DAY) begin
        cal_hour = 0;
        cal_day = (cal_day + 1) & 'h1FF;
        cal_weekday = (cal_weekday + 1) % wk;
        if (cal_weekday == 0) begin
          cal_weekday = wk;
        end
        changed = 1'b1;
      end
      e = read_month(cal_month);
      len = int'(e.days);
      lp = int'(e.leap);
      if (lp != 0 && (cal_year % lp) == 0) begin
        len++;
      end
      if (cal_day > len) begin
        cal_day = 1;
        cal_month++;
        changed = 1'b1;
      end
      if (cal_month > year_len) begin
        cal_month = 1;
        cal_year = (cal_year + 1) & 'hFFFF;
        changed = 1'b1;
      end
      cal_month = cal_month & 'h1F;
      if (changed || !cal_started) begin
        lat_entry = read_month(cal_month);
        cal_started = 1'b1;
      end
    end
    r.date_changed = changed;
    r.minute_now = 6'(cal_minute);
    r.hour_now = 5'(cal_hour);
    r.day_now = 9'(cal_day);
    r.weekday_now = 5'(cal_weekday);
    r.month_now = 5'(cal_month);
    r.year_now = 16'(cal_year);
    r.dawn_hour_out = lat_entry.dawn_h;
    r.dawn_minute_out = lat_entry.dawn_m;
    r.sunset_hour_out = lat_entry.sun_h;
    r.sunset_minute_out = lat_entry.sun_m;
    r.season_out = lat_entry.season;
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    expected_dates.push_back(advance_calendar(it));
    @(negedge clk);
  endtask

  task automatic drain_dates();
    in_if.valid <= 1'b0;
    while (expected_dates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input int val);
    drain_dates();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cfg_data_t'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DAYS_PER_WEEK) begin
      week_len = val & 'h1F;
    end else begin
      year_len = val & 'h1F;
    end
  endtask

  function automatic in_item_t random_item(input logic f);
    in_item_t it;
    it.func = f;
    it.month_index = 5'($urandom_range(31));
    it.month_days = 8'($urandom_range(255));
    it.leap_period = 8'($urandom_range(255));
    it.dawn_hour_in = 5'($urandom_range(23));
    it.dawn_minute_in = 6'($urandom_range(59));
    it.sunset_hour_in = 5'($urandom_range(23));
    it.sunset_minute_in = 6'($urandom_range(59));
    it.season_in = 3'($urandom_range(7));
    return it;
  endfunction

  function automatic in_item_t month_load(input int slot, input int days, input int leap,
                                          input int dh, input int dm, input int sh,
                                          input int sm, input int season);
    in_item_t it;
    it.func = FUNC_LOAD;
    it.month_index = 5'(slot);
    it.month_days = 8'(days);
    it.leap_period = 8'(leap);
    it.dawn_hour_in = 5'(dh);
    it.dawn_minute_in = 6'(dm);
    it.sunset_hour_in = 5'(sh);
    it.sunset_minute_in = 6'(sm);
    it.season_in = 3'(season);
    return it;
  endfunction

  // short months in low slots or near the current one keep the date moving on nearly every tick
  function automatic in_item_t random_month_load();
    in_item_t it;
    int pick;
    it = random_item(FUNC_LOAD);
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.month_index = 5'($urandom_range(4));
    end else if (pick < 75) begin
      it.month_index = 5'(cal_month + $urandom_range(1));
    end
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.month_days = '0;
    end else if (pick < 85) begin
      it.month_days = 8'($urandom_range(1, 3));
    end
    pick = $urandom_range(99);
    if (pick < 50) begin
      it.leap_period = '0;
    end else if (pick < 85) begin
      it.leap_period = 8'($urandom_range(1, 8));
    end
    return it;
  endfunction

  always @(negedge clk) begin
    if (recv_hold > 0) begin
      out_if.ready <= 1'b0;
      recv_hold--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_dates.size() == 0) begin
        report_mismatch("result arrived with nothing expected");
      end else begin
        got = out_if.data;
        want = expected_dates.pop_front();
        check_field("date_changed", int'(got.date_changed), int'(want.date_changed));
        check_field("minute_now", int'(got.minute_now), int'(want.minute_now));
        check_field("hour_now", int'(got.hour_now), int'(want.hour_now));
        check_field("day_now", int'(got.day_now), int'(want.day_now));
        check_field("weekday_now", int'(got.weekday_now), int'(want.weekday_now));
        check_field("month_now", int'(got.month_now), int'(want.month_now));
        check_field("year_now", int'(got.year_now), int'(want.year_now));
        check_field("dawn_hour_out", int'(got.dawn_hour_out), int'(want.dawn_hour_out));
        check_field("dawn_minute_out", int'(got.dawn_minute_out),
                    int'(want.dawn_minute_out));
        check_field("sunset_hour_out", int'(got.sunset_hour_out),
                    int'(want.sunset_hour_out));
        check_field("sunset_minute_out", int'(got.sunset_minute_out),
                    int'(want.sunset_minute_out));
        check_field("season_out", int'(got.season_out), int'(want.season_out));
      end
    end
  end

  task automatic test_first_tick_latch();
    send_item(month_load(1, 2, 0, 6, 15, 20, 45, 3));
    send_item(random_item(FUNC_TICK));
    send_item(month_load(1, 2, 0, 23, 59, 0, 0, 7));
    send_item(random_item(FUNC_TICK));
  endtask

  task automatic test_table_extremes();
    send_item(month_load(0, 255, 255, 23, 59, 23, 59, 7));
    send_item(month_load(31, 0, 0, 0, 0, 0, 0, 0));
    send_item(month_load(2, 0, 255, 4, 10, 18, 5, 1));
  endtask

  task automatic test_empty_months();
    write_register(CFG_MONTHS_PER_YEAR, 3);
    send_item(month_load(1, 0, 0, 5, 20, 21, 40, 2));
    repeat (3) send_item(random_item(FUNC_TICK));
    send_item(month_load(3, 0, 2, 8, 1, 16, 59, 6));
    repeat (3) send_item(random_item(FUNC_TICK));
    send_item(month_load(3, 0, 0, 9, 33, 17, 0, 5));
    send_item(random_item(FUNC_TICK));
  endtask

  task automatic test_register_extremes();
    write_register(CFG_DAYS_PER_WEEK, 0);
    write_register(CFG_MONTHS_PER_YEAR, 0);
    repeat (2) send_item(random_item(FUNC_TICK));
    write_register(CFG_DAYS_PER_WEEK, 31);
    write_register(CFG_MONTHS_PER_YEAR, 31);
    repeat (3) send_item(random_item(FUNC_TICK));
    write_register(CFG_DAYS_PER_WEEK, 1);
    write_register(CFG_MONTHS_PER_YEAR, 1);
    repeat (2) send_item(random_item(FUNC_TICK));
  endtask

  task automatic test_random_calendar(input int n_items, input int snd_pct, input int rcv_pct,
                                      input int wk, input int yr);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    write_register(CFG_DAYS_PER_WEEK, wk);
    write_register(CFG_MONTHS_PER_YEAR, yr);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(199) == 0) begin
        if ($urandom_range(1) != 0) begin
          write_register(CFG_MONTHS_PER_YEAR, $urandom_range(31));
        end else begin
          write_register(CFG_DAYS_PER_WEEK, $urandom_range(31));
        end
      end else if ($urandom_range(99) < 2) begin
        drain_dates();
      end
      if ($urandom_range(99) < 25) begin
        send_item(random_month_load());
      end else begin
        send_item(random_item(FUNC_TICK));
      end
    end
    drain_dates();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    drain_dates();
    recv_hold = 300;
    repeat (12) begin
      if ($urandom_range(3) == 0) begin
        send_item(random_month_load());
      end else begin
        send_item(random_item(FUNC_TICK));
      end
    end
    drain_dates();
  endtask

  task automatic run_hours(input int wk, input int n_hours);
    int rolled;
    bit is_load;
    in_item_t it;
    rolled = 0;
    write_register(CFG_DAYS_PER_WEEK, wk);
    while (rolled < n_hours) begin
      is_load = ($urandom_range(49) == 0);
      if (is_load) begin
        it = random_item(FUNC_LOAD);
        it.month_index = 5'($urandom_range(1, 3));
        it.month_days = 8'($urandom_range(3));
        it.leap_period = 8'($urandom_range(4));
      end else begin
        it = random_item(FUNC_TICK);
        if (cal_minute == MIN_PER_HOUR - 1) begin
          rolled++;
        end
      end
      send_item(it);
    end
  endtask

  task automatic test_hour_rollover();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(CFG_MONTHS_PER_YEAR, 3);
    send_item(month_load(1, 1, 0, 6, 0, 18, 0, 1));
    send_item(month_load(2, 2, 3, 7, 12, 19, 48, 2));
    send_item(month_load(3, 1, 2, 8, 45, 17, 15, 4));
    run_hours(31, 1);
    run_hours(2, 1);
    run_hours(0, 1);
    drain_dates();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DAYS_PER_WEEK;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    foreach (month_tab[i]) month_tab[i] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 7;
    recv_idle_pct = 55;
    test_first_tick_latch();
    test_table_extremes();
    test_empty_months();
    test_register_extremes();
    test_random_calendar(225, 7, 55, 7, 12);
    test_output_backpressure();
    test_random_calendar(225, 55, 7, 1, 31);
    test_random_calendar(225, 0, 0, 31, 2);
    test_hour_rollover();
    drain_dates();
    repeat (50) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
